// ===== sv/mips64_mult_div_unit_top_macros.svh =====
// assertion macros for the multiply-divide unit
// used by mips64_mult_div_unit_top, no other dependencies
`ifndef MIPS64_MULT_DIV_UNIT_TOP_MACROS_SVH
`define MIPS64_MULT_DIV_UNIT_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define MDU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdu assertion failed");

// next-cycle implication, checked out of reset
`define MDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdu assertion failed");

`endif

// ===== sv/mdu_pkg.sv =====
// shared types and constants of the multiply-divide unit
// no dependencies
package mdu_pkg;

    localparam int FIELD_W = 64;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_SMUL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UMUL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SDIV = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UDIV = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_dp_ctrl;

endpackage

// ===== sv/mdu_datapath.sv =====
// bit-serial shift-add multiply and restoring divide datapath, one bit per step
// depends on mdu_pkg
module mdu_datapath #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                        i_clk,
    input  mdu_pkg::t_dp_ctrl           i_ctrl,
    input  logic [mdu_pkg::MODE_W-1:0]  i_mode,
    input  logic [DATA_WIDTH-1:0]       i_a,
    input  logic [DATA_WIDTH-1:0]       i_b,
    output logic [DATA_WIDTH-1:0]       o_hi,
    output logic [DATA_WIDTH-1:0]       o_lo
);

    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic [DATA_WIDTH-1:0] r_q, n_q;
    logic [DATA_WIDTH-1:0] r_b, n_b;
    logic                  r_div, n_div;
    logic                  r_neg_hi, n_neg_hi;
    logic                  r_neg_lo, n_neg_lo;

    logic                  is_div;
    logic                  is_signed;
    logic                  neg_a;
    logic                  neg_b;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH:0]   sum;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  hi_carry;

    always_comb begin
        is_div    = (i_mode == mdu_pkg::MODE_SDIV) || (i_mode == mdu_pkg::MODE_UDIV);
        is_signed = (i_mode == mdu_pkg::MODE_SMUL) || (i_mode == mdu_pkg::MODE_SDIV);
        neg_a     = is_signed & i_a[DATA_WIDTH-1];
        neg_b     = is_signed & i_b[DATA_WIDTH-1];
        mag_a     = neg_a ? (~i_a + DATA_WIDTH'(1)) : i_a;
        mag_b     = neg_b ? (~i_b + DATA_WIDTH'(1)) : i_b;

        sum       = {1'b0, r_acc} + (r_q[0] ? {1'b0, r_b} : '0);
        shifted   = {r_acc, r_q[DATA_WIDTH-1]};
        diff      = shifted - {1'b0, r_b};
        // a remainder always negates with +1, a product high half only on a zero low half
        hi_carry  = r_div | (r_q == '0);
    end

    always_comb begin
        n_acc    = r_acc;
        n_q      = r_q;
        n_b      = r_b;
        n_div    = r_div;
        n_neg_hi = r_neg_hi;
        n_neg_lo = r_neg_lo;
        if (i_ctrl.load) begin
            n_acc    = '0;
            n_q      = mag_a;
            n_b      = mag_b;
            n_div    = is_div;
            n_neg_lo = neg_a ^ neg_b;
            n_neg_hi = is_div ? neg_a : (neg_a ^ neg_b);
        end else if (i_ctrl.step) begin
            if (r_div) begin
                if (!diff[DATA_WIDTH]) begin
                    n_acc = diff[DATA_WIDTH-1:0];
                    n_q   = {r_q[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    n_acc = shifted[DATA_WIDTH-1:0];
                    n_q   = {r_q[DATA_WIDTH-2:0], 1'b0};
                end
            end else begin
                n_acc = sum[DATA_WIDTH:1];
                n_q   = {sum[0], r_q[DATA_WIDTH-1:1]};
            end
        end else if (i_ctrl.fix) begin
            if (r_neg_lo) begin
                n_q = ~r_q + DATA_WIDTH'(1);
            end
            if (r_neg_hi) begin
                n_acc = ~r_acc + DATA_WIDTH'(hi_carry);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_q      <= n_q;
        r_b      <= n_b;
        r_div    <= n_div;
        r_neg_hi <= n_neg_hi;
        r_neg_lo <= n_neg_lo;
    end

    assign o_hi = r_acc;
    assign o_lo = r_q;

endmodule

// ===== sv/mips64_mult_div_unit_top.sv =====
// HI/LO multiply-divide unit, top level: control sequencer and HI/LO result register
// depends on mdu_pkg, mdu_datapath and mips64_mult_div_unit_top_macros.svh
//
// usage:
//   input beats on the s_axis group: tuser carries the operation (signed or
//   unsigned multiply or divide), tdata the two 64-bit operands
//   result beats on the m_axis group: tdata carries HI and LO after the
//   operation, tuser the divide-by-zero flag
//   a beat is accepted when tvalid and tready are high at a rising edge
//   an operation runs from acceptance to a valid result as DATA_WIDTH
//   single-bit shift-add or shift-subtract steps, one sign fix-up step and
//   one write step; a divide by zero skips the steps and the fix-up step
//   one item is in work at a time, so a new beat is not taken until the
//   last result has been written
//   the result register is also the HI/LO state; it is free to be reloaded
//   in the cycle its beat is taken, so a waiting result does not stop the
//   next operation from being accepted and run, only from being written
//   a stalled receiver holds the block in its write step
//   reset (synchronous, active low) clears HI, LO and all control state
`include "mips64_mult_div_unit_top_macros.svh"

module mips64_mult_div_unit_top #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // operand_a [63:0], operand_b [127:64]
    input  logic [2*mdu_pkg::FIELD_W-1:0]     i_s_axis_tdata,
    // mode [1:0]
    input  logic [mdu_pkg::MODE_W-1:0]        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // hi_value [63:0], lo_value [127:64]
    output logic [2*mdu_pkg::FIELD_W-1:0]     o_m_axis_tdata,
    // divide_by_zero [0]
    output logic                              o_m_axis_tuser
);

    localparam int FW    = mdu_pkg::FIELD_W;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    mdu_pkg::t_state       r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_dz, n_dz;
    logic                  r_odz, n_odz;
    logic [DATA_WIDTH-1:0] r_hi, n_hi;
    logic [DATA_WIDTH-1:0] r_lo, n_lo;
    logic                  r_ovalid, n_ovalid;

    mdu_pkg::t_dp_ctrl     dp_ctrl;
    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_b;
    logic [DATA_WIDTH-1:0] dp_hi;
    logic [DATA_WIDTH-1:0] dp_lo;
    logic                  s_acc;
    logic                  is_div;
    logic                  b_zero;
    logic                  slot_free;
    logic                  out_load;

    assign op_a      = i_s_axis_tdata[DATA_WIDTH-1:0];
    assign op_b      = i_s_axis_tdata[FW+DATA_WIDTH-1:FW];
    assign is_div    = (i_s_axis_tuser == mdu_pkg::MODE_SDIV) ||
                       (i_s_axis_tuser == mdu_pkg::MODE_UDIV);
    assign b_zero    = (op_b == '0);
    assign s_acc     = i_s_axis_tvalid & o_s_axis_tready;
    assign slot_free = !r_ovalid || i_m_axis_tready;

    mdu_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_ctrl (dp_ctrl),
        .i_mode (i_s_axis_tuser),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_hi   (dp_hi),
        .o_lo   (dp_lo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mdu_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_state = (is_div && b_zero) ? mdu_pkg::S_WRITE : mdu_pkg::S_RUN;
                end
            end
            mdu_pkg::S_RUN: begin
                if (r_cnt == '0) begin
                    n_state = mdu_pkg::S_FIX;
                end
            end
            mdu_pkg::S_FIX: begin
                n_state = mdu_pkg::S_WRITE;
            end
            mdu_pkg::S_WRITE: begin
                if (slot_free) begin
                    n_state = mdu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mdu_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        dp_ctrl         = '0;
        out_load        = 1'b0;
        case (r_state)
            mdu_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                dp_ctrl.load    = i_s_axis_tvalid;
            end
            mdu_pkg::S_RUN: begin
                dp_ctrl.step = 1'b1;
            end
            mdu_pkg::S_FIX: begin
                dp_ctrl.fix = 1'b1;
            end
            mdu_pkg::S_WRITE: begin
                out_load = slot_free;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_dz     = r_dz;
        n_odz    = r_odz;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_ovalid = r_ovalid & !i_m_axis_tready;
        if (s_acc) begin
            n_cnt = CNT_W'(DATA_WIDTH - 1);
            n_dz  = is_div & b_zero;
        end else if (dp_ctrl.step) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
        if (out_load) begin
            n_ovalid = 1'b1;
            n_odz    = r_dz;
            // a zero divisor keeps HI and LO
            if (!r_dz) begin
                n_hi = dp_hi;
                n_lo = dp_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mdu_pkg::S_IDLE;
            r_cnt    <= '0;
            r_dz     <= 1'b0;
            r_odz    <= 1'b0;
            r_hi     <= '0;
            r_lo     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_dz     <= n_dz;
            r_odz    <= n_odz;
            r_hi     <= n_hi;
            r_lo     <= n_lo;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {FW'(r_lo), FW'(r_hi)};
    assign o_m_axis_tuser  = r_odz;

    `MDU_ASSERT_NEXT(a_dz_skips_steps, i_clk, i_rst_n, s_acc && is_div && b_zero, r_state == mdu_pkg::S_WRITE)
    `MDU_ASSERT_NEXT(a_last_step_fixes, i_clk, i_rst_n, r_state == mdu_pkg::S_RUN && r_cnt == '0, r_state == mdu_pkg::S_FIX)
    `MDU_ASSERT_NOW(a_no_dz_in_steps, i_clk, i_rst_n, r_state == mdu_pkg::S_RUN || r_state == mdu_pkg::S_FIX, !r_dz)
    `MDU_ASSERT_NEXT(a_write_fills_slot, i_clk, i_rst_n, out_load, r_ovalid && r_state == mdu_pkg::S_IDLE)
    `MDU_ASSERT_NEXT(a_held_beat_stable, i_clk, i_rst_n, r_ovalid && !i_m_axis_tready, r_ovalid && $stable(o_m_axis_tdata) && $stable(r_odz))

endmodule

// ===== sim/tb_mips64_mult_div_unit_top.sv =====
// self-checking bench for the hi/lo multiply-divide unit: a directed table then random beats, every result beat
// checked against the hi/lo/dz a table row gives, or else against a hi/lo predictor kept in step with the block
// depends on mdu_pkg and mips64_mult_div_unit_top
`timescale 1ns / 100ps

module tb_mips64_mult_div_unit_top;

    localparam int W = mdu_pkg::FIELD_W;
    localparam int MW = mdu_pkg::MODE_W;
    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM = 500;

    typedef struct packed {
        logic [W-1:0] hi;
        logic [W-1:0] lo;
        logic         dz;
    } t_hilo;

    typedef struct packed {
        logic [MW-1:0] mode;
        logic [W-1:0]  a;
        logic [W-1:0]  b;
        logic          typed;
        logic [W-1:0]  hi;
        logic [W-1:0]  lo;
        logic          dz;
    } t_dir_row;

    localparam logic [W-1:0] ONES = {W{1'b1}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [2*W-1:0]        i_s_axis_tdata = '0;
    logic [MW-1:0]         i_s_axis_tuser = mdu_pkg::MODE_SMUL;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [2*W-1:0]        o_m_axis_tdata;
    logic                  o_m_axis_tuser;

    logic [W-1:0] hi_state = '0;
    logic [W-1:0] lo_state = '0;
    t_hilo        hilo_pending[$];
    bit           throttle = 1'b1;
    int           fault_count = 0;
    int           results_seen = 0;
    int           mul_beats = 0;
    int           div_beats = 0;
    int           zero_div_beats = 0;

    t_dir_row directed_rows [N_DIRECTED] = '{
        // mode, operand_a, operand_b, typed, hi / lo / dz
        '{mdu_pkg::MODE_SDIV, 64'd5, 64'd0, 1'b1, 64'd0, 64'd0, 1'b1},
        '{mdu_pkg::MODE_UDIV, 64'd0, 64'd0, 1'b1, 64'd0, 64'd0, 1'b1},
        '{mdu_pkg::MODE_SMUL, MIN_NEG, MIN_NEG, 1'b1,
          64'h4000_0000_0000_0000, 64'd0, 1'b0},
        '{mdu_pkg::MODE_UMUL, ONES, ONES, 1'b1,
          64'hffff_ffff_ffff_fffe, 64'd1, 1'b0},
        '{mdu_pkg::MODE_SMUL, ONES, ONES, 1'b1, 64'd0, 64'd1, 1'b0},
        '{mdu_pkg::MODE_SMUL, MIN_NEG, ONES, 1'b1, 64'd0, MIN_NEG, 1'b0},
        '{mdu_pkg::MODE_UMUL, MIN_NEG, 64'd2, 1'b1, 64'd1, 64'd0, 1'b0},
        '{mdu_pkg::MODE_SMUL, MAX_POS, MAX_POS, 1'b0, 64'd0, 64'd0, 1'b0},
        '{mdu_pkg::MODE_SMUL, ONES, 64'd1, 1'b1, ONES, ONES, 1'b0},
        '{mdu_pkg::MODE_SDIV, MIN_NEG, ONES, 1'b1, 64'd0, MIN_NEG, 1'b0},
        '{mdu_pkg::MODE_UDIV, 64'd5, 64'd0, 1'b1, 64'd0, MIN_NEG, 1'b1},
        '{mdu_pkg::MODE_SDIV, MIN_NEG, 64'd1, 1'b1, 64'd0, MIN_NEG, 1'b0},
        '{mdu_pkg::MODE_SDIV, -64'sd7, 64'd2, 1'b1,
          ONES, 64'hffff_ffff_ffff_fffd, 1'b0},
        '{mdu_pkg::MODE_SDIV, 64'd7, -64'sd2, 1'b1,
          64'd1, 64'hffff_ffff_ffff_fffd, 1'b0},
        '{mdu_pkg::MODE_SDIV, -64'sd7, -64'sd2, 1'b1, ONES, 64'd3, 1'b0},
        '{mdu_pkg::MODE_UDIV, ONES, 64'd1, 1'b1, 64'd0, ONES, 1'b0},
        '{mdu_pkg::MODE_UDIV, ONES, ONES, 1'b1, 64'd0, 64'd1, 1'b0},
        '{mdu_pkg::MODE_UDIV, MIN_NEG, ONES, 1'b1, MIN_NEG, 64'd0, 1'b0},
        '{mdu_pkg::MODE_SDIV, 64'd0, ONES, 1'b1, 64'd0, 64'd0, 1'b0},
        '{mdu_pkg::MODE_UDIV, 64'h0123_4567_89ab_cdef, 64'h1000, 1'b0,
          64'd0, 64'd0, 1'b0},
        '{mdu_pkg::MODE_SDIV, MAX_POS, MIN_NEG, 1'b0, 64'd0, 64'd0, 1'b0},
        '{mdu_pkg::MODE_SMUL, 64'd0, 64'h5a5a_a5a5_0f0f_f0f0, 1'b0,
          64'd0, 64'd0, 1'b0},
        '{mdu_pkg::MODE_SDIV, 64'h1234, 64'd0, 1'b0, 64'd0, 64'd0, 1'b0},
        '{mdu_pkg::MODE_UMUL, 64'h1234_5678_9abc_def0, 64'hfedc_ba98_7654_3210, 1'b0,
          64'd0, 64'd0, 1'b0}
    };

    mips64_mult_div_unit_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // hi/lo after one operation; keeps the registers on a zero divisor
    function automatic t_hilo hilo_after(input logic [MW-1:0] mode,
                                         input logic [W-1:0] a, input logic [W-1:0] b);
        logic [2*W-1:0] prod;
        logic [W-1:0]   mag_a;
        logic [W-1:0]   mag_b;
        logic [W-1:0]   quot;
        logic [W-1:0]   rem;
        logic           is_signed;
        logic           neg_a;
        logic           neg_b;
        t_hilo          res;
        is_signed = (mode == mdu_pkg::MODE_SMUL) || (mode == mdu_pkg::MODE_SDIV);
        res.dz = 1'b0;
        if (mode == mdu_pkg::MODE_SMUL || mode == mdu_pkg::MODE_UMUL) begin
            prod = {{W{is_signed & a[W-1]}}, a} * {{W{is_signed & b[W-1]}}, b};
            hi_state = prod[2*W-1:W];
            lo_state = prod[W-1:0];
        end else if (b == '0) begin
            res.dz = 1'b1;
        end else begin
            neg_a = is_signed & a[W-1];
            neg_b = is_signed & b[W-1];
            mag_a = neg_a ? -a : a;
            mag_b = neg_b ? -b : b;
            quot = mag_a / mag_b;
            rem = mag_a % mag_b;
            lo_state = (neg_a != neg_b) ? -quot : quot;
            hi_state = neg_a ? -rem : rem;
        end
        res.hi = hi_state;
        res.lo = lo_state;
        return res;
    endfunction

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 64'd1;
            2: return ONES;
            3: return MIN_NEG;
            4: return MAX_POS;
            5: return W'($urandom_range(0, 255));
            6: return -W'($urandom_range(1, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_beat(input logic [MW-1:0] mode, input logic [W-1:0] a,
                             input logic [W-1:0] b, input bit typed, input t_hilo typed_res);
        t_hilo res;
        while (throttle && $urandom_range(0, 99) < 38) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {b, a};
        i_s_axis_tuser <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        res = hilo_after(mode, a, b);
        hilo_pending.push_back(typed ? typed_res : res);
        if (mode == mdu_pkg::MODE_SMUL || mode == mdu_pkg::MODE_UMUL) begin
            mul_beats++;
        end else begin
            div_beats++;
        end
        if (res.dz) begin
            zero_div_beats++;
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (hilo_pending.size() != 0);
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= !throttle || ($urandom_range(0, 99) >= 38);
    end

    always @(posedge i_clk) begin
        t_hilo got;
        t_hilo want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tdata[W-1:0], o_m_axis_tdata[2*W-1:W], o_m_axis_tuser};
            results_seen++;
            if (hilo_pending.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected result beat: hi %h lo %h dz %b",
                             got.hi, got.lo, got.dz);
                end
            end else begin
                want = hilo_pending.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("result %0d mismatch: hi %h/%h lo %h/%h dz %b/%b (exp/got)",
                                 results_seen, want.hi, got.hi, want.lo, got.lo,
                                 want.dz, got.dz);
                    end
                end
            end
        end
    end

    initial begin
        logic [MW-1:0] mode;
        logic [W-1:0]  a;
        logic [W-1:0]  b;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].mode, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].typed,
                      '{directed_rows[i].hi, directed_rows[i].lo, directed_rows[i].dz});
        end
        wait_drained();
        for (int i = 0; i < N_RANDOM; i++) begin
            throttle = !(i >= 180 && i < 300);
            if (i == 250) begin
                wait_drained();
            end
            mode = MW'($urandom_range(0, 3));
            a = pick_operand();
            b = pick_operand();
            send_beat(mode, a, b, 1'b0, '0);
        end
        wait_drained();
        repeat (W + 10) @(posedge i_clk);
        $display("%0d multiply and %0d divide beats sent, %0d of them with a zero divisor",
                 mul_beats, div_beats, zero_div_beats);
        $display("%0d result beats checked, %0d faults", results_seen, fault_count);
        if (fault_count == 0 && hilo_pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mdu_pkg.sv
sv/mdu_datapath.sv
sv/mips64_mult_div_unit_top.sv
sim/tb_mips64_mult_div_unit_top.sv
